// File: src/lkv_pkg.sv
// shared types and codes for the linear key-value table
`timescale 1ns / 1ps

package lkv_pkg;

  typedef enum logic [1:0] {
    ST_IDLE  = 2'd0,
    ST_CMP   = 2'd1,
    ST_SWEEP = 2'd2,
    ST_UPD   = 2'd3
  } state_t;

  typedef enum logic [1:0] {
    OP_PUT    = 2'd0,
    OP_GET    = 2'd1,
    OP_DELETE = 2'd2,
    OP_NOP    = 2'd3
  } op_t;

  // per-cycle commands broadcast to every cell
  typedef struct packed {
    logic cmp;
    logic sweep;
    logic wr_val;
    logic append;
    logic shift;
  } cell_ctl_t;

  // result flags from the sequencer in the update cycle
  typedef struct packed {
    logic valid;
    logic found;
    logic drop;
    logic take_value;
  } result_t;

endpackage

// File: src/lkv_cell.sv
// one table entry with its compare, gather and shift-down logic
`timescale 1ns / 1ps

module lkv_cell
  import lkv_pkg::*;
#(
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32,
  parameter int CNT_W       = 5,
  parameter int IDX         = 0
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  cell_ctl_t              ctl,
  input  logic [KEY_WIDTH-1:0]   q_key,
  input  logic [VALUE_WIDTH-1:0] q_value,
  input  logic [CNT_W-1:0]       count,
  // from the cell above
  input  logic [KEY_WIDTH-1:0]   nb_key,
  input  logic [VALUE_WIDTH-1:0] nb_value,
  input  logic                   acc_found_in,
  input  logic [VALUE_WIDTH-1:0] acc_value_in,
  // from the cell below
  input  logic                   mark_in,
  output logic [KEY_WIDTH-1:0]   key,
  output logic [VALUE_WIDTH-1:0] value,
  output logic                   acc_found,
  output logic [VALUE_WIDTH-1:0] acc_value,
  output logic                   mark
);

  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] value_r;
  logic                   hit_r;
  logic                   acc_found_r;
  logic [VALUE_WIDTH-1:0] acc_value_r;
  logic                   mark_r;
  logic                   in_use;
  logic                   is_tail;

  assign in_use  = CNT_W'(IDX) < count;
  assign is_tail = CNT_W'(IDX) == count;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hit_r       <= 1'b0;
      acc_found_r <= 1'b0;
      acc_value_r <= '0;
      mark_r      <= 1'b0;
    end else if (ctl.cmp) begin
      hit_r       <= in_use && (key_r == q_key);
      acc_found_r <= 1'b0;
      acc_value_r <= '0;
      mark_r      <= 1'b0;
    end else if (ctl.sweep) begin
      acc_found_r <= acc_found_in | hit_r;
      acc_value_r <= acc_value_in | (hit_r ? value_r : '0);
      mark_r      <= mark_in | hit_r;
    end
  end

  // entry contents, no reset
  always_ff @(posedge clk) begin
    if (ctl.wr_val && hit_r) begin
      value_r <= q_value;
    end else if (ctl.append && is_tail) begin
      key_r   <= q_key;
      value_r <= q_value;
    end else if (ctl.shift && mark_r) begin
      key_r   <= nb_key;
      value_r <= nb_value;
    end
  end

  assign key       = key_r;
  assign value     = value_r;
  assign acc_found = acc_found_r;
  assign acc_value = acc_value_r;
  assign mark      = mark_r;

endmodule

// File: src/lkv_ctrl.sv
// sequencer: compare, sweep and update phases, entry count
`timescale 1ns / 1ps

module lkv_ctrl
  import lkv_pkg::*;
#(
  parameter int CAPACITY = 16,
  parameter int CNT_W    = 5
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             start,
  input  op_t              op,
  input  logic             key_zero,
  input  logic             any_hit,
  output logic             busy,
  output cell_ctl_t        ctl,
  output result_t          res,
  output logic [CNT_W-1:0] count
);

  state_t           state_r, state_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      cnt_r   <= '0;
      count_r <= '0;
    end else begin
      state_r <= state_nxt;
      cnt_r   <= cnt_nxt;
      count_r <= count_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cnt_nxt   = cnt_r;
    count_nxt = count_r;
    ctl       = '0;
    res       = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (start) state_nxt = ST_CMP;
      end
      ST_CMP: begin
        ctl.cmp   = 1'b1;
        cnt_nxt   = '0;
        state_nxt = ST_SWEEP;
      end
      ST_SWEEP: begin
        ctl.sweep = 1'b1;
        if (cnt_r == CNT_W'(CAPACITY - 1)) begin
          state_nxt = ST_UPD;
        end else begin
          cnt_nxt = cnt_r + 1'b1;
        end
      end
      ST_UPD: begin
        res.valid = 1'b1;
        state_nxt = ST_IDLE;
        unique case (op)
          OP_PUT: begin
            if (any_hit) begin
              ctl.wr_val = 1'b1;
              res.found  = 1'b1;
            end else if (count_r < CNT_W'(CAPACITY)) begin
              ctl.append = 1'b1;
              count_nxt  = count_r + 1'b1;
            end else begin
              res.drop = 1'b1;
            end
          end
          OP_GET: begin
            if (any_hit && !key_zero) begin
              res.found      = 1'b1;
              res.take_value = 1'b1;
            end
          end
          OP_DELETE: begin
            if (any_hit) begin
              ctl.shift      = 1'b1;
              res.found      = 1'b1;
              res.take_value = 1'b1;
              count_nxt      = count_r - 1'b1;
            end
          end
          default: ;
        endcase
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assign busy  = (state_r != ST_IDLE);
  assign count = count_r;

endmodule

// File: src/linear_key_value_table_top.sv
// top level of the linear key-value table: a row of entry cells and a sequencer
// the result strobe is registered from the update state, which follows the compare and sweep states
// a new item is taken only once the block is idle again; the pace is set by the gather sweep down the cell row
// the receiver cannot stall: out_strobe is high for exactly one cycle per item
// reset: synchronous active-low rst_n empties the table; entry contents are not cleared
`timescale 1ns / 1ps

module linear_key_value_table_top
  import lkv_pkg::*;
#(
  parameter int CAPACITY    = 16,
  parameter int KEY_WIDTH   = 32,
  parameter int VALUE_WIDTH = 32,
  localparam int CNT_W      = $clog2(CAPACITY + 1)
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  output logic                   busy,
  input  logic [1:0]             in_operation,
  input  logic [KEY_WIDTH-1:0]   in_key,
  input  logic [VALUE_WIDTH-1:0] in_value_in,
  output logic                   out_strobe,
  output logic                   out_found,
  output logic [VALUE_WIDTH-1:0] out_value_out,
  output logic                   out_full_drop,
  output logic [CNT_W-1:0]       out_entries
);

  // latched item
  op_t                    op_r;
  logic [KEY_WIDTH-1:0]   key_r;
  logic [VALUE_WIDTH-1:0] value_r;

  // result registers
  logic                   strobe_r;
  logic                   found_r;
  logic [VALUE_WIDTH-1:0] value_out_r;
  logic                   drop_r;

  cell_ctl_t              ctl;
  result_t                res;
  logic [CNT_W-1:0]       count;
  logic                   accept;

  // per-cell taps of the row
  logic [KEY_WIDTH-1:0]   c_key       [CAPACITY];
  logic [VALUE_WIDTH-1:0] c_value     [CAPACITY];
  logic                   c_acc_found [CAPACITY];
  logic [VALUE_WIDTH-1:0] c_acc_value [CAPACITY];
  logic                   c_mark      [CAPACITY];

  assign accept = start && !busy;

  // capture the item on accept; held for the whole operation
  always_ff @(posedge clk) begin
    if (accept) begin
      op_r    <= op_t'(in_operation);
      key_r   <= in_key;
      value_r <= in_value_in;
    end
  end

  lkv_ctrl #(
    .CAPACITY (CAPACITY),
    .CNT_W    (CNT_W)
  ) u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .op       (op_r),
    .key_zero (key_r == '0),
    .any_hit  (c_acc_found[0]),
    .busy     (busy),
    .ctl      (ctl),
    .res      (res),
    .count    (count)
  );

  // cell i gathers from i+1 (toward cell 0) and marks from i-1 (toward the tail)
  // at the end of the sweep state cell 0 holds the hit value and every cell at or
  // above the hit holds its mark, so a delete shifts the upper part down by one
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    logic [KEY_WIDTH-1:0]   nb_key;
    logic [VALUE_WIDTH-1:0] nb_value;
    logic                   nb_found;
    logic [VALUE_WIDTH-1:0] nb_acc;
    logic                   lo_mark;

    if (i == CAPACITY - 1) begin : g_tail
      assign nb_key   = '0;
      assign nb_value = '0;
      assign nb_found = 1'b0;
      assign nb_acc   = '0;
    end else begin : g_body
      assign nb_key   = c_key[i+1];
      assign nb_value = c_value[i+1];
      assign nb_found = c_acc_found[i+1];
      assign nb_acc   = c_acc_value[i+1];
    end

    if (i == 0) begin : g_head
      assign lo_mark = 1'b0;
    end else begin : g_up
      assign lo_mark = c_mark[i-1];
    end

    lkv_cell #(
      .KEY_WIDTH   (KEY_WIDTH),
      .VALUE_WIDTH (VALUE_WIDTH),
      .CNT_W       (CNT_W),
      .IDX         (i)
    ) u_cell (
      .clk          (clk),
      .rst_n        (rst_n),
      .ctl          (ctl),
      .q_key        (key_r),
      .q_value      (value_r),
      .count        (count),
      .nb_key       (nb_key),
      .nb_value     (nb_value),
      .acc_found_in (nb_found),
      .acc_value_in (nb_acc),
      .mark_in      (lo_mark),
      .key          (c_key[i]),
      .value        (c_value[i]),
      .acc_found    (c_acc_found[i]),
      .acc_value    (c_acc_value[i]),
      .mark         (c_mark[i])
    );
  end

  // result register, loaded in the update cycle
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      strobe_r <= 1'b0;
    end else begin
      strobe_r <= res.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res.valid) begin
      found_r     <= res.found;
      drop_r      <= res.drop;
      value_out_r <= res.take_value ? c_acc_value[0] : '0;
    end
  end

  assign out_strobe    = strobe_r;
  assign out_found     = found_r;
  assign out_full_drop = drop_r;
  assign out_value_out = value_out_r;
  // count register updates on the same edge as the result register
  assign out_entries   = count;

endmodule

// File: src/lkv_checker.sv
// port-level checks for the linear key-value table, bound to the top level
`timescale 1ns / 1ps

module lkv_checker #(
  parameter int CAPACITY    = 16,
  parameter int VALUE_WIDTH = 32,
  parameter int CNT_W       = 5
) (
  input logic                   clk,
  input logic                   rst_n,
  input logic                   start,
  input logic                   busy,
  input logic                   out_strobe,
  input logic                   out_found,
  input logic [VALUE_WIDTH-1:0] out_value_out,
  input logic                   out_full_drop,
  input logic [CNT_W-1:0]       out_entries
);

  // an accepted item keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted item did not raise busy");

  // results never come back to back
  a_strobe_gap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two result strobes in a row");

  // a dropped put never reports a match
  a_drop_found: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> !(out_full_drop && out_found))
    else $error("full_drop and found together");

  // no match means a zero value
  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && !out_found) |-> (out_value_out == '0))
    else $error("nonzero value without a match");

  // entry count stays within capacity
  a_count_cap: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_entries <= CNT_W'(CAPACITY)))
    else $error("entry count above capacity");

endmodule

bind linear_key_value_table_top lkv_checker #(
  .CAPACITY    (CAPACITY),
  .VALUE_WIDTH (VALUE_WIDTH),
  .CNT_W       (CNT_W)
) u_lkv_checker (
  .clk           (clk),
  .rst_n         (rst_n),
  .start         (start),
  .busy          (busy),
  .out_strobe    (out_strobe),
  .out_found     (out_found),
  .out_value_out (out_value_out),
  .out_full_drop (out_full_drop),
  .out_entries   (out_entries)
);

// File: tb/tb.sv
// testbench for the linear key-value table: directed rows, then random put/get/delete traffic
`timescale 1ns / 1ps

module tb
  import lkv_pkg::*;
();

  localparam int CAPACITY  = 16;
  localparam int KW        = 32;
  localparam int VW        = 32;
  localparam int CW        = 5;
  localparam int RAND_ITEMS = 1300;
  localparam int CALM_ITEMS = 150;   // tail of the random part runs with no idling
  localparam int DRAIN_WAIT = 25;    // extra wait once no result is owed
  localparam int STALL_LIMIT = 2000; // cycles with neither an accepted item nor a result
  localparam int POOL_SIZE  = 20;

  // one result of the table, as predicted or as typed into a directed row
  typedef struct packed {
    logic          found;
    logic [VW-1:0] value;
    logic          drop;
    logic [CW-1:0] entries;
  } tbl_resp_t;

  // one directed row; has_resp marks rows whose result is typed in
  typedef struct {
    op_t       op;
    logic [KW-1:0] key;
    logic [VW-1:0] val;
    bit        has_resp;
    tbl_resp_t resp;
  } tbl_row_t;

  logic          clk;
  logic          rst_n;
  logic          start;
  logic          busy;
  logic [1:0]    in_operation;
  logic [KW-1:0] in_key;
  logic [VW-1:0] in_value_in;
  logic          out_strobe;
  logic          out_found;
  logic [VW-1:0] out_value_out;
  logic          out_full_drop;
  logic [CW-1:0] out_entries;

  linear_key_value_table_top #(
    .CAPACITY    (CAPACITY),
    .KEY_WIDTH   (KW),
    .VALUE_WIDTH (VW)
  ) u_dut (
    .clk           (clk),
    .rst_n         (rst_n),
    .start         (start),
    .busy          (busy),
    .in_operation  (in_operation),
    .in_key        (in_key),
    .in_value_in   (in_value_in),
    .out_strobe    (out_strobe),
    .out_found     (out_found),
    .out_value_out (out_value_out),
    .out_full_drop (out_full_drop),
    .out_entries   (out_entries)
  );

  // shadow copy of the table contents, kept in the model's own order
  logic [KW-1:0] shadow_keys [CAPACITY];
  logic [VW-1:0] shadow_vals [CAPACITY];
  int unsigned   shadow_count;

  // results still owed by the block, oldest first
  tbl_resp_t pending_resps[$];

  tbl_row_t      dir_rows[$];
  logic [KW-1:0] key_pool [POOL_SIZE];

  int unsigned err_count;
  int unsigned stall_cycles;
  int unsigned n_items, n_results, n_hits, n_drops, peak_entries, n_emptied;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // search in entry order; returns shadow_count on a miss
  function automatic int unsigned shadow_find(logic [KW-1:0] k);
    for (int unsigned i = 0; i < shadow_count; i++) begin
      if (shadow_keys[i] == k) return i;
    end
    return shadow_count;
  endfunction

  // applies one operation to the shadow table and returns what the block should report
  function automatic tbl_resp_t table_apply(op_t op, logic [KW-1:0] k, logic [VW-1:0] v);
    tbl_resp_t   r;
    int unsigned slot;
    r = '0;
    slot = shadow_find(k);
    case (op)
      OP_PUT: begin
        if (slot < shadow_count) begin
          // existing key: overwrite in place, even on a full table
          shadow_vals[slot] = v;
          r.found = 1'b1;
        end else if (shadow_count < CAPACITY) begin
          shadow_keys[shadow_count] = k;
          shadow_vals[shadow_count] = v;
          shadow_count++;
        end else begin
          r.drop = 1'b1;
        end
      end
      OP_GET: begin
        // key zero never hits on a lookup
        if (k != '0 && slot < shadow_count) begin
          r.found = 1'b1;
          r.value = shadow_vals[slot];
        end
      end
      OP_DELETE: begin
        if (slot < shadow_count) begin
          r.found = 1'b1;
          r.value = shadow_vals[slot];
          // last entry moves down into the freed slot
          shadow_count--;
          shadow_keys[slot] = shadow_keys[shadow_count];
          shadow_vals[slot] = shadow_vals[shadow_count];
        end
      end
      default: ;
    endcase
    r.entries = CW'(shadow_count);
    return r;
  endfunction

  task automatic report_mismatch(string what, logic [VW-1:0] got, logic [VW-1:0] want);
    err_count++;
    $display("[%0t] mismatch on %s: got %h, expected %h", $time, what, got, want);
  endtask

  function automatic tbl_row_t mk_row(op_t op, logic [KW-1:0] k, logic [VW-1:0] v,
                                      bit typed, tbl_resp_t r);
    tbl_row_t row;
    row.op       = op;
    row.key      = k;
    row.val      = v;
    row.has_resp = typed;
    row.resp     = r;
    return row;
  endfunction

  // present one item from the next falling edge and hold it until the block takes it;
  // the expectation is queued at the accepting edge
  task automatic send_item(op_t op, logic [KW-1:0] k, logic [VW-1:0] v,
                           bit typed, tbl_resp_t typed_resp);
    tbl_resp_t r;
    @(negedge clk);
    start        <= 1'b1;
    in_operation <= op;
    in_key       <= k;
    in_value_in  <= v;
    do @(posedge clk); while (busy);
    r = table_apply(op, k, v);
    pending_resps.push_back(typed ? typed_resp : r);
    n_items++;
  endtask

  // sender idle burst; start drops first so a held item is not taken twice.
  // sometimes the burst is lined up with the end of the block's work, so the
  // gap lands after busy falls instead of being hidden under it
  task automatic idle_burst();
    int unsigned n;
    n = $urandom_range(6, 1);
    @(negedge clk);
    start        <= 1'b0;
    in_operation <= 2'($urandom);
    in_key       <= $urandom;
    in_value_in  <= $urandom;
    if ($urandom_range(1, 0) == 1) begin
      while (busy) @(negedge clk);
    end
    repeat (n - 1) @(negedge clk);
  endtask

  // result checker: every strobe must match the oldest expectation field by field
  always @(posedge clk) begin
    tbl_resp_t want;
    if (rst_n && out_strobe) begin
      if (pending_resps.size() == 0) begin
        err_count++;
        $display("[%0t] result strobe with no item outstanding", $time);
      end else begin
        want = pending_resps.pop_front();
        n_results++;
        if (out_found !== want.found)
          report_mismatch("found", VW'(out_found), VW'(want.found));
        if (out_value_out !== want.value)
          report_mismatch("value_out", out_value_out, want.value);
        if (out_full_drop !== want.drop)
          report_mismatch("full_drop", VW'(out_full_drop), VW'(want.drop));
        if (out_entries !== want.entries)
          report_mismatch("entries", VW'(out_entries), VW'(want.entries));
        if (want.found) n_hits++;
        if (want.drop) n_drops++;
        if (32'(want.entries) > peak_entries) peak_entries = 32'(want.entries);
      end
    end
  end

  // watchdog: a run of cycles with no accepted item and no result ends the run
  always @(posedge clk) begin
    if ((start && !busy) || out_strobe) begin
      stall_cycles <= 0;
    end else begin
      stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
        $display("[%0t] no progress for %0d cycles", $time, STALL_LIMIT);
        $display("FAIL linear_key_value_table_top");
        $finish;
      end
    end
  end

  initial begin
    tbl_row_t    row;
    int unsigned put_pct, pick, prev_count;
    op_t         op;
    logic [KW-1:0] k;
    bit          calm;

    // every input known from time zero; reset held low at the start
    rst_n        = 1'b0;
    start        = 1'b0;
    in_operation = OP_NOP;
    in_key       = '0;
    in_value_in  = '0;
    err_count    = 0;
    stall_cycles = 0;
    n_items      = 0;
    n_results    = 0;
    n_hits       = 0;
    n_drops      = 0;
    n_emptied    = 0;
    peak_entries = 0;
    shadow_count = 0;
    for (int i = 0; i < CAPACITY; i++) begin
      shadow_keys[i] = '0;
      shadow_vals[i] = '0;
    end
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    // directed rows: empty table, key zero, all-ones extremes, overwrite,
    // filling to capacity, drop on full, overwrite on full, delete with gap closing
    dir_rows.push_back(mk_row(OP_GET,    '0, '0, 1'b1, '{1'b0, '0, 1'b0, 5'd0}));
    dir_rows.push_back(mk_row(OP_DELETE, '0, '0, 1'b1, '{1'b0, '0, 1'b0, 5'd0}));
    dir_rows.push_back(mk_row(OP_NOP,    '1, '1, 1'b1, '{1'b0, '0, 1'b0, 5'd0}));
    dir_rows.push_back(mk_row(OP_PUT,    '0, '1, 1'b1, '{1'b0, '0, 1'b0, 5'd1}));
    // key zero can be stored but a lookup never finds it
    dir_rows.push_back(mk_row(OP_GET,    '0, '1, 1'b1, '{1'b0, '0, 1'b0, 5'd1}));
    dir_rows.push_back(mk_row(OP_PUT,    '1, '0, 1'b1, '{1'b0, '0, 1'b0, 5'd2}));
    dir_rows.push_back(mk_row(OP_GET,    '1, '1, 1'b1, '{1'b1, '0, 1'b0, 5'd2}));
    dir_rows.push_back(mk_row(OP_PUT,    '1, 32'hA5A5_A5A5, 1'b1, '{1'b1, '0, 1'b0, 5'd2}));
    for (int i = 1; i <= CAPACITY - 2; i++) begin
      dir_rows.push_back(mk_row(OP_PUT, KW'(i), ~VW'(i), 1'b0, '0));
    end
    // new key on a full table is dropped
    dir_rows.push_back(mk_row(OP_PUT, 32'h8000_0000, 32'h1, 1'b1,
                              '{1'b0, '0, 1'b1, 5'd16}));
    dir_rows.push_back(mk_row(OP_PUT, 32'd7, 32'h5A5A_5A5A, 1'b0, '0));
    // removing entry zero pulls the last entry into its slot
    dir_rows.push_back(mk_row(OP_DELETE, '0, '0, 1'b1, '{1'b1, '1, 1'b0, 5'd15}));
    dir_rows.push_back(mk_row(OP_GET,    32'd14, '0, 1'b0, '0));
    dir_rows.push_back(mk_row(OP_DELETE, '0, '0, 1'b1, '{1'b0, '0, 1'b0, 5'd15}));

    foreach (dir_rows[i]) begin
      row = dir_rows[i];
      send_item(row.op, row.key, row.val, row.has_resp, row.resp);
    end

    // random part: a small pool of keys keeps hits, overwrites and deletes
    // common; the put share changes per phase so the table fills, sits full
    // and drains repeatedly
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) key_pool[i] = $urandom;
    put_pct = 50;
    for (int n = 0; n < RAND_ITEMS; n++) begin
      if (n % 100 == 0) put_pct = $urandom_range(85, 15);
      calm = (n >= RAND_ITEMS - CALM_ITEMS);
      pick = $urandom_range(99, 0);
      if (pick < 4)                op = OP_NOP;
      else if (pick < 4 + put_pct) op = OP_PUT;
      else if ($urandom_range(1, 0) == 1) op = OP_GET;
      else                         op = OP_DELETE;
      if ($urandom_range(99, 0) < 75) k = key_pool[$urandom_range(POOL_SIZE - 1, 0)];
      else                            k = $urandom;
      if (!calm && $urandom_range(99, 0) < 25) idle_burst();
      prev_count = shadow_count;
      send_item(op, k, $urandom, 1'b0, '0);
      if (op == OP_DELETE && prev_count != 0 && shadow_count == 0) n_emptied++;
    end

    @(negedge clk);
    start <= 1'b0;

    // drain: the watchdog covers a result that never comes
    while (pending_resps.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (pending_resps.size() != 0) begin
      err_count++;
      $display("%0d expected results never arrived", pending_resps.size());
    end

    $display("covered %0d items, %0d results: %0d key hits, %0d puts dropped on a full table",
             n_items, n_results, n_hits, n_drops);
    $display("peak occupancy %0d of %0d entries, table emptied by delete %0d times",
             peak_entries, CAPACITY, n_emptied);
    if (err_count == 0) begin
      $display("PASS linear_key_value_table_top");
    end else begin
      $display("FAIL linear_key_value_table_top");
    end
    $finish;
  end

endmodule
